/* sv/led_blink_pattern_sequencer_unit_macros.svh */
// assertion macros used by the checker file
`ifndef LED_BLINK_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define LED_BLINK_PATTERN_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define LBPS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbps assertion failed");

// next-cycle implication, off during reset
`define LBPS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbps assertion failed");

`endif

/* sv/lbps_pkg.sv */
package lbps_pkg;

    // widths fixed by the interface
    localparam int TIME_W     = 16;
    localparam int SINCE_W    = 17;
    localparam int IN_COUNT_W = 8;
    localparam int CFG_IDX_W  = 2;

    // default number of count bits that take part
    localparam int COUNT_BITS_DEF = 8;

    // register reset values
    localparam logic [TIME_W-1:0] ON_TIME_RST     = 16'd100;
    localparam logic [TIME_W-1:0] OFF_TIME_RST    = 16'd100;
    localparam logic [TIME_W-1:0] GROUP_PAUSE_RST = 16'd200;
    localparam logic [TIME_W-1:0] ENDING_GAP_RST  = 16'd400;

    // request codes
    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_OFF     = 3'd1,
        REQ_ON      = 3'd2,
        REQ_TOGGLE  = 3'd3,
        REQ_BLINK   = 3'd4,
        REQ_PATTERN = 3'd5,
        REQ_FLASH   = 3'd6,
        REQ_PAUSE   = 3'd7
    } t_req;

    // led modes
    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_ON      = 2'd1,
        MODE_BLINK   = 2'd2,
        MODE_PATTERN = 2'd3
    } t_mode;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_TIME     = 2'd0,
        CFG_OFF_TIME    = 2'd1,
        CFG_GROUP_PAUSE = 2'd2,
        CFG_ENDING_GAP  = 2'd3
    } t_cfg_idx;

endpackage

/* sv/led_blink_pattern_sequencer_unit.sv */
// channel | direction | handshake              | payload
// in      | input     | i_in_valid/o_in_ready   | req_type, counts, repeat, duration
// out     | output    | o_out_valid/i_out_ready | led_level, led_changed, is_on, mode
// cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// one transaction per cycle when not stalled: the full update runs between the input
// handshake and the result register, so a result shows the cycle after it is taken
// the input side is ready whenever the result register is empty or being drained
// synchronous active-low reset clears mode, timers, overlay and registers to defaults
// a stalled output holds its result and back-pressures the input, no state is lost
module led_blink_pattern_sequencer_unit #(
    parameter int COUNT_BITS = lbps_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command / tick channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_req_type,
    input  logic [lbps_pkg::IN_COUNT_W-1:0] i_count_first,
    input  logic [lbps_pkg::IN_COUNT_W-1:0] i_count_second,
    input  logic                          i_repeat_pattern,
    input  logic [lbps_pkg::TIME_W-1:0]   i_duration_ms,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_led_level,
    output logic                          o_led_changed,
    output logic                          o_is_on,
    output logic [1:0]                    o_mode,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [lbps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lbps_pkg::TIME_W-1:0]   i_cfg_data
);
    import lbps_pkg::*;

    localparam int CNT_W = (COUNT_BITS < IN_COUNT_W) ? COUNT_BITS : IN_COUNT_W;
    localparam logic [SINCE_W-1:0] SINCE_MAX = '1;

    // configuration registers
    logic [TIME_W-1:0] r_on_time_ms, r_off_time_ms, r_group_pause_ms, r_ending_gap_ms;

    // sequencer state
    t_mode              r_mode, n_mode;
    logic               r_level, n_level;
    logic [SINCE_W-1:0] r_since, n_since;
    logic [CNT_W-1:0]   r_left_first, n_left_first;
    logic [CNT_W-1:0]   r_left_second, n_left_second;
    logic [CNT_W-1:0]   r_group_first, n_group_first;
    logic [CNT_W-1:0]   r_group_second, n_group_second;
    logic               r_repeat_on, n_repeat_on;
    logic               r_ovl_active, n_ovl_active;
    logic [TIME_W-1:0]  r_ovl_left, n_ovl_left;
    logic               r_ovl_level, n_ovl_level;

    // result register
    logic               r_out_valid, n_out_valid;
    logic               r_out_level, r_out_changed, r_out_is_on;
    t_mode              r_out_mode;

    logic               accept;
    t_req               req;
    logic [CNT_W-1:0]   cnt_first, cnt_second;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign req        = t_req'(i_req_type);
    assign cnt_first  = i_count_first[CNT_W-1:0];
    assign cnt_second = i_count_second[CNT_W-1:0];

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_time_ms     <= ON_TIME_RST;
            r_off_time_ms    <= OFF_TIME_RST;
            r_group_pause_ms <= GROUP_PAUSE_RST;
            r_ending_gap_ms  <= ENDING_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ON_TIME:     r_on_time_ms     <= i_cfg_data;
                CFG_OFF_TIME:    r_off_time_ms    <= i_cfg_data;
                CFG_GROUP_PAUSE: r_group_pause_ms <= i_cfg_data;
                CFG_ENDING_GAP:  r_ending_gap_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // command handling followed by the timing update
    always_comb begin
        logic on_due, off_due, pause_due, gap_due;
        n_mode         = r_mode;
        n_level        = r_level;
        n_since        = r_since;
        n_left_first   = r_left_first;
        n_left_second  = r_left_second;
        n_group_first  = r_group_first;
        n_group_second = r_group_second;
        n_repeat_on    = r_repeat_on;
        n_ovl_active   = r_ovl_active;
        n_ovl_left     = r_ovl_left;
        n_ovl_level    = r_ovl_level;

        unique case (req) inside
            REQ_TICK: begin
                if (r_since != SINCE_MAX) n_since = r_since + 1'b1;
                if (r_ovl_active) begin
                    if (r_ovl_left == '0) n_ovl_active = 1'b0;
                    else                  n_ovl_left   = r_ovl_left - 1'b1;
                end
            end
            REQ_OFF: begin
                n_mode  = MODE_OFF;
                n_level = 1'b0;
            end
            REQ_ON: begin
                n_mode  = MODE_ON;
                n_level = 1'b1;
            end
            REQ_TOGGLE: begin
                // overlay counts as on
                if (r_ovl_active || r_mode != MODE_OFF) begin
                    n_mode  = MODE_OFF;
                    n_level = 1'b0;
                end else begin
                    n_mode  = MODE_ON;
                    n_level = 1'b1;
                end
            end
            REQ_BLINK: begin
                if (r_mode != MODE_BLINK) begin
                    n_mode  = MODE_BLINK;
                    n_since = '0;
                    n_level = 1'b1;
                end
            end
            REQ_PATTERN: begin
                n_repeat_on = i_repeat_pattern;
                if (r_mode != MODE_PATTERN || r_group_first != cnt_first
                        || r_group_second != cnt_second) begin
                    n_mode         = MODE_PATTERN;
                    n_group_first  = cnt_first;
                    n_group_second = cnt_second;
                    n_left_first   = cnt_first;
                    n_left_second  = cnt_second;
                    n_since        = '0;
                    n_level        = 1'b1;
                end
            end
            REQ_FLASH, REQ_PAUSE: begin
                n_ovl_active = 1'b1;
                n_ovl_left   = i_duration_ms;
                n_ovl_level  = (req == REQ_FLASH);
            end
            default: ;
        endcase

        // timer compares on the post-command time
        on_due    = n_since >= {1'b0, r_on_time_ms};
        off_due   = n_since >= {1'b0, r_off_time_ms};
        pause_due = n_since >= {1'b0, r_group_pause_ms};
        gap_due   = n_since >= {1'b0, r_ending_gap_ms};

        if (n_ovl_active) begin
            n_level = n_ovl_level;
        end else if (n_mode == MODE_BLINK) begin
            if (n_level && on_due) begin
                n_level = 1'b0;
                n_since = '0;
            end else if (!n_level && off_due) begin
                n_level = 1'b1;
                n_since = '0;
            end
        end else if (n_mode == MODE_PATTERN) begin
            if (n_left_first != '0) begin
                if (n_level && on_due) begin
                    n_level      = 1'b0;
                    n_since      = '0;
                    n_left_first = n_left_first - 1'b1;
                end else if (!n_level && off_due) begin
                    n_level = 1'b1;
                    n_since = '0;
                end
            end else if (n_left_second != '0) begin
                // group pause over, second group starts
                if (pause_due) begin
                    n_level       = 1'b1;
                    n_left_first  = n_left_second;
                    n_left_second = '0;
                    n_since       = '0;
                end
            end else if (n_repeat_on) begin
                // ending gap over, pattern restarts
                if (gap_due) begin
                    n_level       = 1'b1;
                    n_left_first  = n_group_first;
                    n_left_second = n_group_second;
                    n_since       = '0;
                end
            end else begin
                n_mode  = MODE_OFF;
                n_level = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_OFF;
            r_level        <= 1'b0;
            r_since        <= '0;
            r_left_first   <= '0;
            r_left_second  <= '0;
            r_group_first  <= '0;
            r_group_second <= '0;
            r_repeat_on    <= 1'b0;
            r_ovl_active   <= 1'b0;
            r_ovl_left     <= '0;
            r_ovl_level    <= 1'b0;
        end else if (accept) begin
            r_mode         <= n_mode;
            r_level        <= n_level;
            r_since        <= n_since;
            r_left_first   <= n_left_first;
            r_left_second  <= n_left_second;
            r_group_first  <= n_group_first;
            r_group_second <= n_group_second;
            r_repeat_on    <= n_repeat_on;
            r_ovl_active   <= n_ovl_active;
            r_ovl_left     <= n_ovl_left;
            r_ovl_level    <= n_ovl_level;
        end
    end

    // result register valid
    always_comb begin
        if (accept)           n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, last driven level is always the stored level
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_level   <= n_level;
            r_out_changed <= n_level != r_level;
            r_out_is_on   <= n_ovl_active || n_mode != MODE_OFF;
            r_out_mode    <= n_mode;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_led_level   = r_out_level;
    assign o_led_changed = r_out_changed;
    assign o_is_on       = r_out_is_on;
    assign o_mode        = r_out_mode;

endmodule

/* sv/lbps_checker.sv */
`include "led_blink_pattern_sequencer_unit_macros.svh"

module lbps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_led_level,
    input logic       o_is_on,
    input logic [1:0] o_mode
);
    import lbps_pkg::*;

    // no result right after reset
    `LBPS_ASSERT_NOW(a_idle_after_reset, i_clk, i_rst_n, !$past(i_rst_n), !o_out_valid)

    // a taken transaction always produces a result next cycle
    `LBPS_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_in_valid && o_in_ready, o_out_valid)

    // any active mode reports the led as on
    `LBPS_ASSERT_NOW(a_mode_on, i_clk, i_rst_n, o_out_valid && o_mode != MODE_OFF, o_is_on)

    // a stalled result holds its level and mode
    `LBPS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_led_level) && $stable(o_mode))

endmodule

bind led_blink_pattern_sequencer_unit lbps_checker u_lbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_led_level (o_led_level),
    .o_is_on     (o_is_on),
    .o_mode      (o_mode)
);
